### rtl/core/stack_with_middle_access_assert.svh
// ---------------------------------------------------------------------------
// Stack with middle access: assertion macros
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH
`define STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define SWMA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define SWMA_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SWMA_ASSERT(label, prop, msg)
`define SWMA_ASSERT_NEVER(label, expr, msg)

`endif

`endif

### rtl/core/swma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stack with middle access: package
// Operation and status codes, controller states and the cell control bundle.
// ---------------------------------------------------------------------------
package swma_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_PUSH    = 2'd0,
        MODE_POP     = 2'd1,
        MODE_DEL_MID = 2'd2,
        MODE_PEEK    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_GATHER = 1'b1
    } state_t;

    // Broadcast to every cell in the cycle an item is accepted.
    typedef struct packed {
        logic push_en;
        logic del_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/core/swma_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stack with middle access: channel interfaces
// Valid/ready channels for the operation items and the result items.
// ---------------------------------------------------------------------------
interface swma_in_if import swma_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface swma_out_if import swma_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] middle_value;
    logic                     is_empty;
    logic [1:0]               status;

    modport source (output valid, output removed_value, output top_value,
                    output middle_value, output is_empty, output status, input ready);
    modport sink   (input valid, input removed_value, input top_value,
                    input middle_value, input is_empty, input status, output ready);
endinterface
`default_nettype wire

### rtl/core/swma_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stack with middle access: storage cell
// One stack entry at a fixed position; loads a push or takes its upper
// neighbor's entry on a delete, and flags itself as top or middle.
// ---------------------------------------------------------------------------
module swma_cell import swma_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int OCC_W = 7
)
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [OCC_W-1:0]  occ,
    input  wire logic [DATA_W-1:0] push_value,
    input  wire logic [DATA_W-1:0] shift_in,
    output logic      [DATA_W-1:0] data,
    output logic      [DATA_W-1:0] top_part,
    output logic      [DATA_W-1:0] mid_part
);

    localparam logic [OCC_W-1:0] MY_POS  = OCC_W'(IDX);
    localparam logic [OCC_W-1:0] MY_NEXT = OCC_W'(IDX + 1);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [OCC_W-1:0]  mid_pos;
    logic              is_top;
    logic              is_mid;

    assign mid_pos = occ >> 1;
    assign is_top  = (occ == MY_NEXT);
    assign is_mid  = (mid_pos == MY_POS) && (occ != '0);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_en && (occ == MY_POS))
        begin
            data_next = push_value;
        end
        else if (ctrl.del_en && (mid_pos <= MY_POS) && (MY_NEXT < occ))
        begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign top_part = is_top ? data_reg : '0;
    assign mid_part = is_mid ? data_reg : '0;

endmodule
`default_nettype wire

### rtl/core/stack_with_middle_access.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Stack with middle access
// Bounded stack of signed 32-bit entries with pop of the top and delete of
// the middle entry, built as a row of storage cells.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                              Item
//  cmd      in   mode, push_value                                     one operation
//  rsp      out  removed_value, top_value, middle_value, is_empty,    one result
//                status
//
// Each item is accepted, then gathered: in the accept cycle the cells update in
// parallel (a delete moves every entry above the middle down by one) and the
// removed value is captured; in the gather state, once the result register is
// free, the new top and middle are gathered from the cells into it.
// The gather is an AND-OR across all DEPTH cells, which sets the cycle time.
// Reset empties the stack and the result register; cell contents are not
// cleared, since entries at or above the occupancy are never read.
// cmd is ready whenever the controller is idle, which includes the time a
// result item waits in the result register. A stalled rsp holds the result;
// a following item may be accepted but waits in the gather cycle.
//
module stack_with_middle_access import swma_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    swma_in_if.sink    cmd,
    swma_out_if.source rsp
);

`include "stack_with_middle_access_assert.svh"

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    // Controller and occupancy.
    state_t            state_reg;
    state_t            state_next;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic              acc;
    mode_t             mode;
    logic              empty;
    logic              full;
    cell_ctrl_t        ctrl;
    logic              load_out;

    // Per-item results captured in the accept cycle.
    logic [DATA_W-1:0] removed_reg;
    logic [DATA_W-1:0] removed_next;
    status_t           status_reg;
    status_t           status_next;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_removed_reg;
    logic [DATA_W-1:0] out_top_reg;
    logic [DATA_W-1:0] out_mid_reg;
    logic              out_empty_reg;
    status_t           out_status_reg;

    // Cell row.
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] shift_in  [DEPTH];
    logic [DATA_W-1:0] top_part  [DEPTH];
    logic [DATA_W-1:0] mid_part  [DEPTH];
    logic [DATA_W-1:0] gather_top;
    logic [DATA_W-1:0] gather_mid;

    assign acc   = cmd.valid && cmd.ready;
    assign mode  = mode_t'(cmd.mode);
    assign empty = (occ_reg == '0);
    assign full  = (occ_reg == OCC_FULL);

    assign ctrl.push_en = acc && (mode == MODE_PUSH) && !full;
    assign ctrl.del_en  = acc && (mode == MODE_DEL_MID) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == DEPTH - 1)
            begin : g_last
                assign shift_in[gi] = '0;
            end
            else
            begin : g_inner
                assign shift_in[gi] = cell_data[gi + 1];
            end

            swma_cell #(
                .IDX   (gi),
                .OCC_W (OCC_W)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ_reg),
                .push_value (cmd.push_value),
                .shift_in   (shift_in[gi]),
                .data       (cell_data[gi]),
                .top_part   (top_part[gi]),
                .mid_part   (mid_part[gi])
            );
        end
    endgenerate

    // Exactly one cell flags itself as top and one as middle when the stack
    // is not empty, so an OR across the row selects them.
    always_comb
    begin
        gather_top = '0;
        gather_mid = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            gather_top = gather_top | top_part[i];
            gather_mid = gather_mid | mid_part[i];
        end
    end

    // Occupancy, status and removed value of the accepted item.
    always_comb
    begin
        occ_next     = occ_reg;
        removed_next = '0;
        status_next  = ST_OK;
        case (mode)
            MODE_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    occ_next = occ_reg + 1'b1;
                end
            end
            MODE_POP:
            begin
                if (empty)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    occ_next     = occ_reg - 1'b1;
                    removed_next = gather_top;
                end
            end
            MODE_DEL_MID:
            begin
                if (empty)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    occ_next     = occ_reg - 1'b1;
                    removed_next = gather_mid;
                end
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    // Controller: accept, then gather once the result register is free.
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        cmd.ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    state_next = S_GATHER;
                end
            end
            S_GATHER:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (acc)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            removed_reg <= removed_next;
            status_reg  <= status_next;
        end
        if (load_out)
        begin
            out_removed_reg <= removed_reg;
            out_top_reg     <= gather_top;
            out_mid_reg     <= gather_mid;
            out_empty_reg   <= empty;
            out_status_reg  <= status_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.top_value     = out_top_reg;
    assign rsp.middle_value  = out_mid_reg;
    assign rsp.is_empty      = out_empty_reg;
    assign rsp.status        = out_status_reg;

    `SWMA_ASSERT_NEVER(a_occ_bound, occ_reg > OCC_FULL, "occupancy exceeds depth")
    `SWMA_ASSERT(a_acc_gather, acc |=> state_reg == S_GATHER, "accept not followed by gather")
    `SWMA_ASSERT(a_push_grow, ctrl.push_en |=> occ_reg == $past(occ_reg) + 1'b1, "push lost")
    `SWMA_ASSERT(a_out_src, $rose(rsp.valid) |-> $past(state_reg) == S_GATHER, "stray result")

endmodule
`default_nettype wire

### bench/swma_bench_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stack with middle access: bench package
// Shadow copy of the stack and the in-order check of its result items.
// ---------------------------------------------------------------------------
package swma_bench_pkg;
    import swma_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int SHOWN_MISMATCHES = 10;

    // What one result item says about the stack after its step.
    typedef struct packed {
        logic signed [DATA_W-1:0] removed;
        logic signed [DATA_W-1:0] top;
        logic signed [DATA_W-1:0] middle;
        logic                     empty;
        status_t                  status;
    } stack_view_t;

    class stack_tracker;
        logic signed [DATA_W-1:0] cells [STACK_DEPTH];
        int unsigned              fill;
        stack_view_t              pending_results [$];
        int unsigned              fail_count;

        function new();
            fill = 0;
            fail_count = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Applies one accepted operation to the shadow stack and queues the
        // result item that the block owes for it.
        function void note_op(mode_t op, logic signed [DATA_W-1:0] value);
            stack_view_t view;
            int unsigned mid;
            view = '0;
            view.status = ST_OK;
            case (op)
                MODE_PUSH:
                begin
                    if (fill >= STACK_DEPTH)
                    begin
                        view.status = ST_OVER;
                    end
                    else
                    begin
                        cells[fill] = value;
                        fill++;
                    end
                end
                MODE_POP:
                begin
                    if (fill == 0)
                    begin
                        view.status = ST_UNDER;
                    end
                    else
                    begin
                        fill--;
                        view.removed = cells[fill];
                    end
                end
                MODE_DEL_MID:
                begin
                    if (fill == 0)
                    begin
                        view.status = ST_UNDER;
                    end
                    else
                    begin
                        mid = fill >> 1;
                        view.removed = cells[mid];
                        for (int unsigned i = mid; i + 1 < fill; i++)
                        begin
                            cells[i] = cells[i + 1];
                        end
                        fill--;
                    end
                end
                default:
                begin
                end
            endcase
            if (fill == 0)
            begin
                view.empty = 1'b1;
            end
            else
            begin
                view.top    = cells[fill - 1];
                view.middle = cells[fill >> 1];
            end
            pending_results.push_back(view);
        endfunction

        function void flag(string what, stack_view_t want, stack_view_t got);
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
            begin
                $display("MISMATCH (%s) want: rem=%0d top=%0d mid=%0d empty=%b st=%0d",
                         what, want.removed, want.top, want.middle, want.empty,
                         want.status);
                $display("                 got: rem=%0d top=%0d mid=%0d empty=%b st=%0d",
                         got.removed, got.top, got.middle, got.empty, got.status);
            end
        endfunction

        // Compares one accepted result item with the oldest one owed.
        function void check_result(stack_view_t got);
            stack_view_t want;
            if (pending_results.size() == 0)
            begin
                flag("nothing pending", '0, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.removed !== want.removed || got.top !== want.top ||
                    got.middle !== want.middle || got.empty !== want.empty ||
                    got.status !== want.status)
                begin
                    flag("field", want, got);
                end
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0)
            begin
                fail_count += pending_results.size();
                $display("MISSING: %0d result items never arrived", pending_results.size());
            end
        endfunction
    endclass

endpackage

### bench/stack_with_middle_access_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stack with middle access: testbench
// Drives push, pop, delete-middle and peek items with random gaps on both
// channels and checks every result item against a shadow stack.
// ---------------------------------------------------------------------------
module stack_with_middle_access_tb;
    import swma_pkg::*;
    import swma_bench_pkg::*;

    localparam int RANDOM_ITEMS = 1930;
    // Cycles that the receiver holds off at the pressure points.
    localparam int HOLD_CYCLES = 160;
    // Cycles allowed after the last result.
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;

    swma_in_if  cmd_ch ();
    swma_out_if rsp_ch ();

    stack_tracker tracker;
    int unsigned  sent_count;

    stack_with_middle_access #(
        .DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The whole run must fit well inside this; a hang ends here.
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Offers one operation item after a random gap and returns at the edge
    // where it is accepted. When the gap is zero, valid simply stays high,
    // so it is never lowered and raised in the same time step. Every 256
    // items the first 48 go out back to back.
    task automatic send_op(mode_t op, logic signed [DATA_W-1:0] value);
        int unsigned gap;
        gap = ((sent_count % 256) < 48) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.mode       <= op;
        cmd_ch.push_value <= value;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        sent_count++;
    endtask

    // Both handshakes are sampled at the clock edge, where the values seen
    // are the ones from before the edge. The result is checked before the
    // new item is noted, so a result arriving at the same edge as an
    // operation is matched only against older operations.
    always @(posedge clk)
    begin
        stack_view_t got;
        if (rst_n === 1'b1)
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.removed = rsp_ch.removed_value;
                got.top     = rsp_ch.top_value;
                got.middle  = rsp_ch.middle_value;
                got.empty   = rsp_ch.is_empty;
                got.status  = status_t'(rsp_ch.status);
                tracker.check_result(got);
            end
            if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
            begin
                tracker.note_op(mode_t'(cmd_ch.mode), cmd_ch.push_value);
            end
        end
    end

    // Receiver. It may stall before each result item, except for
    // an unstalled stretch every 200 items. At two points it holds off for
    // a long time, so the block fills up and the sender sees ready drop.
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall = ((taken % 200) < 40) ? 0 : $urandom_range(0, 4);
            if (taken == 500 || taken == 1400)
            begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);
            taken++;
        end
    end

    // Sender, reset and end of run.
    initial
    begin
        int unsigned phase_no;
        int unsigned phase_left;
        int unsigned push_cut;
        int unsigned pop_cut;
        int unsigned del_cut;
        int unsigned roll;
        mode_t       op;
        logic signed [DATA_W-1:0] value;

        tracker    = new();
        sent_count = 0;
        phase_no   = 0;
        phase_left = 0;
        push_cut   = 0;
        pop_cut    = 0;
        del_cut    = 0;

        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.mode       <= MODE_PEEK;
        cmd_ch.push_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. On the empty stack a peek reports empty with status
        // ok, while pop and delete report underflow. Then the field extremes
        // are pushed, the middle is deleted at odd and even counts, and the
        // stack is drained by pops until one more pop underflows.
        send_op(MODE_PEEK,    $urandom());
        send_op(MODE_POP,     $urandom());
        send_op(MODE_DEL_MID, $urandom());
        send_op(MODE_PUSH,    32'sh7FFF_FFFF);
        send_op(MODE_PEEK,    $urandom());
        send_op(MODE_DEL_MID, $urandom());
        send_op(MODE_PUSH,    32'sh8000_0000);
        send_op(MODE_PUSH,    32'sh0000_0001);
        send_op(MODE_PUSH,    32'shFFFF_FFFF);
        send_op(MODE_PUSH,    32'sh0000_0000);
        send_op(MODE_PUSH,    32'sh7FFF_FFFF);
        send_op(MODE_PEEK,    $urandom());
        send_op(MODE_DEL_MID, $urandom());
        send_op(MODE_DEL_MID, $urandom());
        send_op(MODE_POP,     $urandom());
        send_op(MODE_POP,     $urandom());
        send_op(MODE_POP,     $urandom());
        send_op(MODE_POP,     $urandom());
        send_op(MODE_DEL_MID, $urandom());

        // Random part, in phases that cycle through fill, drain, mixed and
        // peek-heavy mixes. A fill phase pushes hard enough to reach a full
        // stack and overflow it; a drain phase empties it and underflows.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(40, 120);
                case (phase_no % 4)
                    0:
                    begin
                        push_cut = 92; pop_cut = 95; del_cut = 98;
                    end
                    1:
                    begin
                        push_cut = 8; pop_cut = 50; del_cut = 94;
                    end
                    2:
                    begin
                        push_cut = 40; pop_cut = 60; del_cut = 85;
                    end
                    default:
                    begin
                        push_cut = 30; pop_cut = 40; del_cut = 50;
                    end
                endcase
                phase_no++;
            end
            phase_left--;

            roll = $urandom_range(0, 99);
            if (roll < push_cut)
            begin
                op = MODE_PUSH;
            end
            else if (roll < pop_cut)
            begin
                op = MODE_POP;
            end
            else if (roll < del_cut)
            begin
                op = MODE_DEL_MID;
            end
            else
            begin
                op = MODE_PEEK;
            end

            // The value is random on every item, pushes or not, with the
            // extremes and values near zero drawn often.
            case ($urandom_range(0, 7))
                0:       value = 32'sh8000_0000;
                1:       value = 32'sh7FFF_FFFF;
                2:       value = $urandom_range(0, 15);
                3:       value = 32'shFFFF_FFFF - $urandom_range(0, 15);
                default: value = $urandom();
            endcase

            send_op(op, value);
        end
        cmd_ch.valid <= 1'b0;

        // Wait for every owed result item, then a few more cycles to catch
        // any stray one.
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.close_out();

        if (tracker.fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### stack_with_middle_access.f
+incdir+rtl/core
rtl/core/swma_pkg.sv
rtl/core/swma_ifs.sv
rtl/core/swma_cell.sv
rtl/core/stack_with_middle_access.sv
bench/swma_bench_pkg.sv
bench/stack_with_middle_access_tb.sv
